>>> rtl/qtg_pkg.sv
// Shared types, constants and the sequencer program store for the quintic
// trajectory generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qtg_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int ACC_W         = 64;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int NUM_CFG       = 8;
  localparam int SLOT_DEPTH    = 16;
  localparam int SLOT_AW       = 4;
  localparam int PC_W          = 7;
  localparam int ARG_W         = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd7;
  localparam logic [CFG_W-1:0] DURATION_RESET   = 32'd65536;
  localparam logic [CFG_W-1:0] STEP_RESET       = 32'd6554;

  localparam logic [PC_W-1:0] SAMPLE_ENTRY = 7'd0;
  localparam logic [PC_W-1:0] SOLVE_ENTRY  = 7'd66;

  localparam logic signed [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_LDR, OP_LDC, OP_LDT, OP_STR, OP_ADD, OP_SUB, OP_NEG, OP_HALF,
    OP_MULQ, OP_MULK, OP_DIVQ, OP_TAU, OP_OUT, OP_END, OP_GOSAMP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ARG_W-1:0] arg;
  } instr_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_MUL_LO, S_MUL_HI, S_MUL_FIN, S_DIV
  } state_t;

  // scratch slots
  localparam logic [ARG_W-1:0] A_C0   = 5'd0;
  localparam logic [ARG_W-1:0] A_C1   = 5'd1;
  localparam logic [ARG_W-1:0] A_C2   = 5'd2;
  localparam logic [ARG_W-1:0] A_C3   = 5'd3;
  localparam logic [ARG_W-1:0] A_C4   = 5'd4;
  localparam logic [ARG_W-1:0] A_C5   = 5'd5;
  localparam logic [ARG_W-1:0] A_AT   = 5'd6;
  localparam logic [ARG_W-1:0] A_B0   = 5'd7;
  localparam logic [ARG_W-1:0] A_B1T  = 5'd8;
  localparam logic [ARG_W-1:0] A_B2T2 = 5'd9;
  localparam logic [ARG_W-1:0] A_B2H  = 5'd10;
  localparam logic [ARG_W-1:0] A_TMP  = 5'd11;
  localparam logic [ARG_W-1:0] A_TMP2 = 5'd12;
  localparam logic [ARG_W-1:0] A_RH   = 5'd13;
  // multiplier / output selects
  localparam logic [ARG_W-1:0] SRC_D   = 5'd0;
  localparam logic [ARG_W-1:0] SRC_T   = 5'd1;
  localparam logic [ARG_W-1:0] SRC_TAU = 5'd2;
  localparam logic [ARG_W-1:0] OUT_P   = 5'd0;
  localparam logic [ARG_W-1:0] OUT_V   = 5'd1;
  localparam logic [ARG_W-1:0] OUT_A   = 5'd2;
  localparam logic [ARG_W-1:0] A_NONE  = 5'd0;
  // register indexes for loads
  localparam logic [ARG_W-1:0] R_PS = 5'd0;
  localparam logic [ARG_W-1:0] R_VS = 5'd1;
  localparam logic [ARG_W-1:0] R_AS = 5'd2;
  localparam logic [ARG_W-1:0] R_PE = 5'd3;
  localparam logic [ARG_W-1:0] R_VE = 5'd4;
  localparam logic [ARG_W-1:0] R_AE = 5'd5;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
      s = a[ACC_W-1] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_neg(input logic signed [ACC_W-1:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  // truncates toward zero
  function automatic logic signed [ACC_W-1:0] halve(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    t = a + {{(ACC_W-1){1'b0}}, a[ACC_W-1]};
    return t >>> 1;
  endfunction

  function automatic logic signed [CFG_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
    logic signed [CFG_W-1:0] r;
    if (a[ACC_W-1:CFG_W-1] == '0 || a[ACC_W-1:CFG_W-1] == '1) r = a[CFG_W-1:0];
    else if (a[ACC_W-1]) r = {1'b1, {(CFG_W-1){1'b0}}};
    else r = {1'b0, {(CFG_W-1){1'b1}}};
    return r;
  endfunction

  // Accumulator program: sample evaluation from SAMPLE_ENTRY, solve from SOLVE_ENTRY.
  function automatic instr_t prog_word(input logic [PC_W-1:0] pc);
    instr_t w;
    case (pc)
      7'd0:   w = '{OP_LDT,  A_NONE};
      7'd1:   w = '{OP_DIVQ, A_NONE};
      7'd2:   w = '{OP_TAU,  A_NONE};
      7'd3:   w = '{OP_LDR,  A_C5};
      7'd4:   w = '{OP_MULQ, SRC_TAU};
      7'd5:   w = '{OP_ADD,  A_C4};
      7'd6:   w = '{OP_MULQ, SRC_TAU};
      7'd7:   w = '{OP_ADD,  A_C3};
      7'd8:   w = '{OP_MULQ, SRC_TAU};
      7'd9:   w = '{OP_MULQ, SRC_TAU};
      7'd10:  w = '{OP_MULQ, SRC_TAU};
      7'd11:  w = '{OP_STR,  A_TMP};
      7'd12:  w = '{OP_LDR,  A_C2};
      7'd13:  w = '{OP_MULQ, SRC_T};
      7'd14:  w = '{OP_MULQ, SRC_T};
      7'd15:  w = '{OP_HALF, A_NONE};
      7'd16:  w = '{OP_STR,  A_RH};
      7'd17:  w = '{OP_LDR,  A_C1};
      7'd18:  w = '{OP_MULQ, SRC_T};
      7'd19:  w = '{OP_STR,  A_TMP2};
      7'd20:  w = '{OP_LDR,  A_C0};
      7'd21:  w = '{OP_ADD,  A_TMP2};
      7'd22:  w = '{OP_ADD,  A_RH};
      7'd23:  w = '{OP_ADD,  A_TMP};
      7'd24:  w = '{OP_OUT,  OUT_P};
      7'd25:  w = '{OP_LDR,  A_C4};
      7'd26:  w = '{OP_MULK, 5'd4};
      7'd27:  w = '{OP_STR,  A_TMP};
      7'd28:  w = '{OP_LDR,  A_C3};
      7'd29:  w = '{OP_MULK, 5'd3};
      7'd30:  w = '{OP_STR,  A_TMP2};
      7'd31:  w = '{OP_LDR,  A_C5};
      7'd32:  w = '{OP_MULK, 5'd5};
      7'd33:  w = '{OP_MULQ, SRC_TAU};
      7'd34:  w = '{OP_ADD,  A_TMP};
      7'd35:  w = '{OP_MULQ, SRC_TAU};
      7'd36:  w = '{OP_ADD,  A_TMP2};
      7'd37:  w = '{OP_MULQ, SRC_TAU};
      7'd38:  w = '{OP_MULQ, SRC_TAU};
      7'd39:  w = '{OP_DIVQ, A_NONE};
      7'd40:  w = '{OP_STR,  A_TMP};
      7'd41:  w = '{OP_LDR,  A_C2};
      7'd42:  w = '{OP_MULQ, SRC_T};
      7'd43:  w = '{OP_STR,  A_TMP2};
      7'd44:  w = '{OP_LDR,  A_C1};
      7'd45:  w = '{OP_ADD,  A_TMP2};
      7'd46:  w = '{OP_ADD,  A_TMP};
      7'd47:  w = '{OP_OUT,  OUT_V};
      7'd48:  w = '{OP_LDR,  A_C4};
      7'd49:  w = '{OP_MULK, 5'd12};
      7'd50:  w = '{OP_STR,  A_TMP};
      7'd51:  w = '{OP_LDR,  A_C3};
      7'd52:  w = '{OP_MULK, 5'd6};
      7'd53:  w = '{OP_STR,  A_TMP2};
      7'd54:  w = '{OP_LDR,  A_C5};
      7'd55:  w = '{OP_MULK, 5'd20};
      7'd56:  w = '{OP_MULQ, SRC_TAU};
      7'd57:  w = '{OP_ADD,  A_TMP};
      7'd58:  w = '{OP_MULQ, SRC_TAU};
      7'd59:  w = '{OP_ADD,  A_TMP2};
      7'd60:  w = '{OP_MULQ, SRC_TAU};
      7'd61:  w = '{OP_DIVQ, A_NONE};
      7'd62:  w = '{OP_DIVQ, A_NONE};
      7'd63:  w = '{OP_ADD,  A_C2};
      7'd64:  w = '{OP_OUT,  OUT_A};
      7'd65:  w = '{OP_END,  A_NONE};
      // coefficient solve
      7'd66:  w = '{OP_LDC,  R_PS};
      7'd67:  w = '{OP_STR,  A_C0};
      7'd68:  w = '{OP_LDC,  R_VS};
      7'd69:  w = '{OP_STR,  A_C1};
      7'd70:  w = '{OP_LDC,  R_AS};
      7'd71:  w = '{OP_STR,  A_C2};
      7'd72:  w = '{OP_MULQ, SRC_D};
      7'd73:  w = '{OP_STR,  A_AT};
      7'd74:  w = '{OP_LDC,  R_VS};
      7'd75:  w = '{OP_MULQ, SRC_D};
      7'd76:  w = '{OP_STR,  A_TMP};
      7'd77:  w = '{OP_LDR,  A_AT};
      7'd78:  w = '{OP_MULQ, SRC_D};
      7'd79:  w = '{OP_HALF, A_NONE};
      7'd80:  w = '{OP_STR,  A_TMP2};
      7'd81:  w = '{OP_LDC,  R_PE};
      7'd82:  w = '{OP_SUB,  A_C0};
      7'd83:  w = '{OP_SUB,  A_TMP};
      7'd84:  w = '{OP_SUB,  A_TMP2};
      7'd85:  w = '{OP_STR,  A_B0};
      7'd86:  w = '{OP_LDC,  R_VE};
      7'd87:  w = '{OP_SUB,  A_C1};
      7'd88:  w = '{OP_SUB,  A_AT};
      7'd89:  w = '{OP_MULQ, SRC_D};
      7'd90:  w = '{OP_STR,  A_B1T};
      7'd91:  w = '{OP_LDC,  R_AE};
      7'd92:  w = '{OP_SUB,  A_C2};
      7'd93:  w = '{OP_MULQ, SRC_D};
      7'd94:  w = '{OP_MULQ, SRC_D};
      7'd95:  w = '{OP_STR,  A_B2T2};
      7'd96:  w = '{OP_HALF, A_NONE};
      7'd97:  w = '{OP_STR,  A_B2H};
      7'd98:  w = '{OP_LDR,  A_B1T};
      7'd99:  w = '{OP_MULK, 5'd4};
      7'd100: w = '{OP_STR,  A_TMP};
      7'd101: w = '{OP_LDR,  A_B0};
      7'd102: w = '{OP_MULK, 5'd10};
      7'd103: w = '{OP_SUB,  A_TMP};
      7'd104: w = '{OP_ADD,  A_B2H};
      7'd105: w = '{OP_STR,  A_C3};
      7'd106: w = '{OP_LDR,  A_B1T};
      7'd107: w = '{OP_MULK, 5'd7};
      7'd108: w = '{OP_STR,  A_TMP};
      7'd109: w = '{OP_LDR,  A_B0};
      7'd110: w = '{OP_MULK, 5'd15};
      7'd111: w = '{OP_NEG,  A_NONE};
      7'd112: w = '{OP_ADD,  A_TMP};
      7'd113: w = '{OP_SUB,  A_B2T2};
      7'd114: w = '{OP_STR,  A_C4};
      7'd115: w = '{OP_LDR,  A_B1T};
      7'd116: w = '{OP_MULK, 5'd3};
      7'd117: w = '{OP_STR,  A_TMP};
      7'd118: w = '{OP_LDR,  A_B0};
      7'd119: w = '{OP_MULK, 5'd6};
      7'd120: w = '{OP_SUB,  A_TMP};
      7'd121: w = '{OP_ADD,  A_B2H};
      7'd122: w = '{OP_STR,  A_C5};
      7'd123: w = '{OP_GOSAMP, A_NONE};
      default: w = '{OP_END, A_NONE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/qtg_in_if.sv
// Tick channel of the quintic trajectory generator: valid/ready and the restart bit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface qtg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

>>> rtl/qtg_out_if.sv
// Sample channel of the quintic trajectory generator: valid/ready and one sample word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface qtg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] acceleration;
  logic        [31:0] sample_time;
  logic               last_sample;
  logic               past_end;
  logic               setup_error;
  modport source (output valid, output position, output velocity, output acceleration,
                  output sample_time, output last_sample, output past_end,
                  output setup_error, input ready);
  modport sink   (input valid, input position, input velocity, input acceleration,
                  input sample_time, input last_sample, input past_end,
                  input setup_error, output ready);
endinterface
`default_nettype wire

>>> rtl/qtg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module qtg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/quintic_trajectory_generator.sv
// Single-axis quintic trajectory generator, top level: config registers, microcoded
// sequencer with one shared 32x32 multiplier and a bit-serial divider.
// Depends on qtg_pkg, qtg_in_if, qtg_out_if, qtg_ram.
//
//  channel | dir | handshake      | payload
//  in_ch   | in  | valid / ready  | restart
//  out_ch  | out | valid / ready  | position, velocity, acceleration, sample_time,
//          |     |                | last_sample, past_end, setup_error
//  cfg_*   | in  | cfg_we only    | cfg_index (0..7), cfg_data (32 bits)
//
// One word at a time: in_ch.ready is high only when the sequencer is idle and the
// output register is empty. A plain tick runs 66 microinstructions, with extra
// states for each multiply and for each of the 4 divides, in Q16.16 by default.
// A restart adds the 58-step solve. Ticks with no run answer straight from idle.
// The divider's one-bit-per-cycle loop takes most of the run time.
// Reset is synchronous; the scratch RAM needs no clearing since it is written before use.
`timescale 1ns / 1ps
`default_nettype none
module quintic_trajectory_generator #(
  parameter int FRAC_BITS = qtg_pkg::DEF_FRAC_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  qtg_in_if.sink                              in_ch,
  qtg_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [qtg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qtg_pkg::CFG_W-1:0]      cfg_data
);
  localparam int AW    = qtg_pkg::ACC_W;
  localparam int QW    = AW + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  qtg_pkg::state_t state_r, state_nxt;
  logic [qtg_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic [AW-1:0] mag_r, mag_nxt;
  logic neg_r, neg_nxt;
  logic [AW-1:0] prod_lo_r, prod_lo_nxt, prod_hi_r, prod_hi_nxt;
  logic [QW-1:0] dq_r, dq_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0] tau_r, tau_nxt, time_r, time_nxt, run_d_r, run_d_nxt, run_s_r, run_s_nxt;
  logic fin_r, fin_nxt, err_r, err_nxt;
  logic [qtg_pkg::CFG_W-1:0] cfg_r [qtg_pkg::NUM_CFG];
  logic signed [31:0] pos_r, pos_nxt, vel_r, vel_nxt, accel_r, accel_nxt;
  logic [31:0] stime_r, stime_nxt;
  logic last_r, last_nxt, past_r, past_nxt, oerr_r, oerr_nxt, ovalid_r, ovalid_nxt;

  qtg_pkg::instr_t instr;
  logic in_acc, setup_bad;
  logic [AW-1:0] acc_mag, rdata, mul_p;
  logic [31:0] mul_a, mul_b;
  logic [95:0] full, shq;
  logic signed [AW-1:0] mul_res, div_res;
  logic [AW-1:0] magq, magd;
  logic [32:0] trial, diff, tsum;
  logic ge, ram_we;

  assign instr     = qtg_pkg::prog_word(pc_r);
  assign in_ch.ready = (state_r == qtg_pkg::S_IDLE) && !ovalid_r;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign setup_bad = (cfg_r[qtg_pkg::CFG_DURATION] == '0) || (cfg_r[qtg_pkg::CFG_STEP] == '0);
  assign acc_mag   = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign ram_we    = (state_r == qtg_pkg::S_EXEC) && (instr.op == qtg_pkg::OP_STR);

  qtg_ram #(.WIDTH(AW), .DEPTH(qtg_pkg::SLOT_DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (instr.arg[qtg_pkg::SLOT_AW-1:0]),
    .wdata (acc_r),
    .raddr (instr.arg[qtg_pkg::SLOT_AW-1:0]),
    .rdata (rdata)
  );

  // shared multiplier: low then high half of the magnitude
  always_comb begin
    mul_a = (state_r == qtg_pkg::S_MUL_LO) ? mag_r[31:0] : mag_r[63:32];
    if (instr.op == qtg_pkg::OP_MULK) mul_b = {27'd0, instr.arg};
    else begin
      case (instr.arg)
        qtg_pkg::SRC_D:   mul_b = run_d_r;
        qtg_pkg::SRC_T:   mul_b = time_r;
        qtg_pkg::SRC_TAU: mul_b = tau_r;
        default:          mul_b = tau_r;
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    full = {prod_hi_r, 32'd0} + {32'd0, prod_lo_r};
    shq  = full >> FRAC_BITS;
    if (instr.op == qtg_pkg::OP_MULK) begin
      // smulk saturates an overflowing negative product to the most negative value
      if (|full[95:63]) mul_res = neg_r ? qtg_pkg::S64_MIN : qtg_pkg::S64_MAX;
      else mul_res = neg_r ? -$signed(full[63:0]) : $signed(full[63:0]);
      magq = '0;
    end else begin
      magq = (|shq[95:63]) ? AW'(qtg_pkg::S64_MAX) : shq[63:0];
      mul_res = neg_r ? -$signed(magq) : $signed(magq);
    end
  end

  // restoring divider step and result
  always_comb begin
    trial = {rem_r, dq_r[QW-1]};
    diff  = trial - {1'b0, run_d_r};
    ge    = trial >= {1'b0, run_d_r};
    magd  = (|dq_r[QW-1:AW-1]) ? AW'(qtg_pkg::S64_MAX) : {1'b0, dq_r[AW-2:0]};
    div_res = neg_r ? -$signed(magd) : $signed(magd);
    tsum  = {1'b0, time_r} + {1'b0, run_s_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qtg_pkg::S_IDLE: begin
        if (in_acc && ((in_ch.restart && !setup_bad) || (!in_ch.restart && !fin_r)))
          state_nxt = qtg_pkg::S_FETCH;
      end
      qtg_pkg::S_FETCH: state_nxt = qtg_pkg::S_EXEC;
      qtg_pkg::S_EXEC: begin
        case (instr.op)
          qtg_pkg::OP_MULQ, qtg_pkg::OP_MULK: state_nxt = qtg_pkg::S_MUL_LO;
          qtg_pkg::OP_DIVQ:                   state_nxt = qtg_pkg::S_DIV;
          qtg_pkg::OP_END:                    state_nxt = qtg_pkg::S_IDLE;
          default:                            state_nxt = qtg_pkg::S_FETCH;
        endcase
      end
      qtg_pkg::S_MUL_LO:  state_nxt = qtg_pkg::S_MUL_HI;
      qtg_pkg::S_MUL_HI:  state_nxt = qtg_pkg::S_MUL_FIN;
      qtg_pkg::S_MUL_FIN: state_nxt = qtg_pkg::S_FETCH;
      qtg_pkg::S_DIV:     if (cnt_r == '0) state_nxt = qtg_pkg::S_FETCH;
      default:            state_nxt = qtg_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pc_nxt = pc_r; acc_nxt = acc_r; mag_nxt = mag_r; neg_nxt = neg_r;
    prod_lo_nxt = prod_lo_r; prod_hi_nxt = prod_hi_r;
    dq_nxt = dq_r; rem_nxt = rem_r; cnt_nxt = cnt_r; tau_nxt = tau_r;
    time_nxt = time_r; run_d_nxt = run_d_r; run_s_nxt = run_s_r;
    fin_nxt = fin_r; err_nxt = err_r;
    pos_nxt = pos_r; vel_nxt = vel_r; accel_nxt = accel_r; stime_nxt = stime_r;
    last_nxt = last_r; past_nxt = past_r; oerr_nxt = oerr_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    case (state_r)
      qtg_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.restart) begin
            if (setup_bad) begin
              err_nxt = 1'b1;
              fin_nxt = 1'b1;
            end else begin
              err_nxt   = 1'b0;
              fin_nxt   = 1'b0;
              run_d_nxt = cfg_r[qtg_pkg::CFG_DURATION];
              run_s_nxt = cfg_r[qtg_pkg::CFG_STEP];
              time_nxt  = '0;
              pc_nxt    = qtg_pkg::SOLVE_ENTRY;
            end
          end else pc_nxt = qtg_pkg::SAMPLE_ENTRY;
          // no run: repeat the held word
          if ((in_ch.restart && setup_bad) || (!in_ch.restart && fin_r)) begin
            last_nxt   = 1'b0;
            past_nxt   = 1'b1;
            oerr_nxt   = in_ch.restart ? 1'b1 : err_r;
            ovalid_nxt = 1'b1;
          end
        end
      end
      qtg_pkg::S_EXEC: begin
        pc_nxt = pc_r + 7'd1;
        case (instr.op)
          qtg_pkg::OP_LDR:  acc_nxt = rdata;
          qtg_pkg::OP_LDC:
            acc_nxt = AW'($signed(cfg_r[instr.arg[qtg_pkg::CFG_IDX_W-1:0]]));
          qtg_pkg::OP_LDT:  acc_nxt = {32'd0, time_r};
          qtg_pkg::OP_ADD:  acc_nxt = qtg_pkg::sat_add(acc_r, rdata);
          qtg_pkg::OP_SUB:  acc_nxt = qtg_pkg::sat_add(acc_r, qtg_pkg::sat_neg(rdata));
          qtg_pkg::OP_NEG:  acc_nxt = qtg_pkg::sat_neg(acc_r);
          qtg_pkg::OP_HALF: acc_nxt = qtg_pkg::halve(acc_r);
          qtg_pkg::OP_TAU:  tau_nxt = (|acc_r[63:32]) ? '1 : acc_r[31:0];
          qtg_pkg::OP_MULQ, qtg_pkg::OP_MULK: begin
            // hold pc so the operand select stays on this word
            pc_nxt  = pc_r;
            mag_nxt = acc_mag;
            neg_nxt = acc_r[AW-1];
          end
          qtg_pkg::OP_DIVQ: begin
            dq_nxt  = {acc_mag, {FRAC_BITS{1'b0}}};
            rem_nxt = '0;
            cnt_nxt = CNT_W'(QW);
            neg_nxt = acc_r[AW-1];
          end
          qtg_pkg::OP_OUT: begin
            case (instr.arg)
              qtg_pkg::OUT_P: pos_nxt   = qtg_pkg::sat32(acc_r);
              qtg_pkg::OUT_V: vel_nxt   = qtg_pkg::sat32(acc_r);
              default:        accel_nxt = qtg_pkg::sat32(acc_r);
            endcase
          end
          qtg_pkg::OP_GOSAMP: pc_nxt = qtg_pkg::SAMPLE_ENTRY;
          qtg_pkg::OP_END: begin
            stime_nxt  = time_r;
            last_nxt   = (time_r > run_d_r) || tsum[32];
            past_nxt   = 1'b0;
            oerr_nxt   = err_r;
            ovalid_nxt = 1'b1;
            if ((time_r > run_d_r) || tsum[32]) fin_nxt = 1'b1;
            else time_nxt = tsum[31:0];
          end
          default: acc_nxt = acc_r;
        endcase
      end
      qtg_pkg::S_MUL_LO:  prod_lo_nxt = mul_p;
      qtg_pkg::S_MUL_HI:  prod_hi_nxt = mul_p;
      qtg_pkg::S_MUL_FIN: begin
        acc_nxt = mul_res;
        pc_nxt  = pc_r + 7'd1;
      end
      qtg_pkg::S_DIV: begin
        if (cnt_r != '0) begin
          rem_nxt = ge ? diff[31:0] : trial[31:0];
          dq_nxt  = {dq_r[QW-2:0], ge};
          cnt_nxt = cnt_r - CNT_W'(1);
        end else acc_nxt = div_res;
      end
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= qtg_pkg::S_IDLE;
      pc_r     <= qtg_pkg::SAMPLE_ENTRY;
      fin_r    <= 1'b1;
      err_r    <= 1'b0;
      ovalid_r <= 1'b0;
      time_r   <= '0;
      pos_r    <= '0;
      vel_r    <= '0;
      accel_r  <= '0;
      stime_r  <= '0;
      last_r   <= 1'b0;
      past_r   <= 1'b0;
      oerr_r   <= 1'b0;
      for (int i = 0; i < qtg_pkg::NUM_CFG; i++) begin
        if (i == int'(qtg_pkg::CFG_DURATION)) cfg_r[i] <= qtg_pkg::DURATION_RESET;
        else if (i == int'(qtg_pkg::CFG_STEP)) cfg_r[i] <= qtg_pkg::STEP_RESET;
        else cfg_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      fin_r    <= fin_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
      time_r   <= time_nxt;
      pos_r    <= pos_nxt;
      vel_r    <= vel_nxt;
      accel_r  <= accel_nxt;
      stime_r  <= stime_nxt;
      last_r   <= last_nxt;
      past_r   <= past_nxt;
      oerr_r   <= oerr_nxt;
      if (cfg_we) cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    prod_lo_r <= prod_lo_nxt;
    prod_hi_r <= prod_hi_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    tau_r     <= tau_nxt;
    run_d_r   <= run_d_nxt;
    run_s_r   <= run_s_nxt;
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.position     = pos_r;
  assign out_ch.velocity     = vel_r;
  assign out_ch.acceleration = accel_r;
  assign out_ch.sample_time  = stime_r;
  assign out_ch.last_sample  = last_r;
  assign out_ch.past_end     = past_r;
  assign out_ch.setup_error  = oerr_r;
endmodule
`default_nettype wire

>>> test/qtg_sample_checker.sv
// Sample checker for the quintic trajectory generator: watches the tick, sample and
// register-write ports, predicts every sample and compares it. Depends on qtg_pkg,
// qtg_in_if and qtg_out_if.
`timescale 1ns / 1ps
module qtg_sample_checker (
  input  logic        clk,
  input  logic        rst_n,
  qtg_in_if           in_ch,
  qtg_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  localparam int F = qtg_pkg::DEF_FRAC_BITS;
  localparam longint          L_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint          L_MIN = 64'h8000_0000_0000_0000;
  localparam longint unsigned U_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic [31:0] sample_time;
    logic        last_sample;
    logic        past_end;
    logic        setup_error;
  } sample_t;

  logic [31:0] regs [qtg_pkg::NUM_CFG];
  longint      coef [6];
  logic [31:0] now_t, run_d, run_s;
  logic        finished, err_flag;
  logic [31:0] held [4];
  sample_t     sample_q [$];

  function automatic longint unsigned magnitude(longint a);
    longint unsigned u;
    u = a;
    return (a < 0) ? (64'd0 - u) : u;
  endfunction

  function automatic longint clip_sign(longint unsigned m, bit neg);
    if (m > U_MAX) m = U_MAX;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > L_MAX - b) return L_MAX;
    if (b < 0 && a < L_MIN - b) return L_MIN;
    return a + b;
  endfunction

  function automatic longint flip(longint a);
    return (a == L_MIN) ? L_MAX : -a;
  endfunction

  function automatic longint scale_k(longint a, longint k);
    if (a > L_MAX / k) return L_MAX;
    if (a < L_MIN / k) return L_MIN;
    return a * k;
  endfunction

  // a * b >> F on the magnitude, b unsigned fixed point
  function automatic longint qmul(longint a, logic [31:0] b);
    longint unsigned m, hp, lp, r, add, b64;
    m = magnitude(a);
    b64 = {32'd0, b};
    hp = (m >> 32) * b64;
    lp = (m & 64'hFFFF_FFFF) * b64;
    if (hp > (U_MAX >> (32 - F))) return clip_sign(U_MAX, a < 0);
    r = hp << (32 - F);
    add = lp >> F;
    if (r > U_MAX - add) return clip_sign(U_MAX, a < 0);
    return clip_sign(r + add, a < 0);
  endfunction

  function automatic longint qdiv(longint a, logic [31:0] d);
    longint unsigned m, q, rem, d64;
    m = magnitude(a);
    d64 = {32'd0, d};
    q = m / d64;
    rem = m % d64;
    if (q > (U_MAX >> F)) return clip_sign(U_MAX, a < 0);
    return clip_sign((q << F) + ((rem << F) / d64), a < 0);
  endfunction

  function automatic logic [31:0] to32(longint a);
    if (a > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (a < -64'sh8000_0000) return 32'h8000_0000;
    return a[31:0];
  endfunction

  task automatic solve_coefs();
    longint ps, vs, as, pe, ve, ae, at, b0, b1t, b2t2, b2h;
    ps = $signed(regs[0]); vs = $signed(regs[1]); as = $signed(regs[2]);
    pe = $signed(regs[3]); ve = $signed(regs[4]); ae = $signed(regs[5]);
    at = qmul(as, run_d);
    b0 = sat_sum(sat_sum(sat_sum(pe, flip(ps)), flip(qmul(vs, run_d))),
                 flip(qmul(at, run_d) / 2));
    b1t = qmul(sat_sum(sat_sum(ve, flip(vs)), flip(at)), run_d);
    b2t2 = qmul(qmul(sat_sum(ae, flip(as)), run_d), run_d);
    b2h = b2t2 / 2;
    coef[0] = ps;
    coef[1] = vs;
    coef[2] = as;
    coef[3] = sat_sum(sat_sum(scale_k(b0, 10), flip(scale_k(b1t, 4))), b2h);
    coef[4] = sat_sum(sat_sum(flip(scale_k(b0, 15)), scale_k(b1t, 7)), flip(b2t2));
    coef[5] = sat_sum(sat_sum(scale_k(b0, 6), flip(scale_k(b1t, 3))), b2h);
  endtask

  task automatic predict_sample(logic restart);
    sample_t s;
    longint tq, p, v, a, poly;
    logic [31:0] tau;
    longint unsigned nxt;
    if (restart) begin
      if (regs[qtg_pkg::CFG_DURATION] == 0 || regs[qtg_pkg::CFG_STEP] == 0) begin
        err_flag = 1;
        finished = 1;
      end else begin
        err_flag = 0;
        finished = 0;
        run_d = regs[qtg_pkg::CFG_DURATION];
        run_s = regs[qtg_pkg::CFG_STEP];
        now_t = 0;
        solve_coefs();
      end
    end
    s.last_sample = 0;
    s.past_end = 0;
    s.setup_error = err_flag;
    if (finished || run_d == 0 || run_s == 0) begin
      s.past_end = 1;
    end else begin
      tq = qdiv(longint'({32'd0, now_t}), run_d);
      tau = (tq > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : tq[31:0];
      poly = sat_sum(qmul(sat_sum(qmul(coef[5], tau), coef[4]), tau), coef[3]);
      poly = qmul(qmul(qmul(poly, tau), tau), tau);
      p = sat_sum(sat_sum(sat_sum(coef[0], qmul(coef[1], now_t)),
                  qmul(qmul(coef[2], now_t), now_t) / 2), poly);
      poly = sat_sum(qmul(sat_sum(qmul(scale_k(coef[5], 5), tau), scale_k(coef[4], 4)), tau),
                     scale_k(coef[3], 3));
      poly = qmul(qmul(poly, tau), tau);
      v = sat_sum(sat_sum(coef[1], qmul(coef[2], now_t)), qdiv(poly, run_d));
      poly = sat_sum(qmul(sat_sum(qmul(scale_k(coef[5], 20), tau), scale_k(coef[4], 12)),
                     tau), scale_k(coef[3], 6));
      poly = qmul(poly, tau);
      a = sat_sum(coef[2], qdiv(qdiv(poly, run_d), run_d));
      held[0] = to32(p);
      held[1] = to32(v);
      held[2] = to32(a);
      held[3] = now_t;
      nxt = {32'd0, now_t} + {32'd0, run_s};
      if (now_t > run_d || nxt > 64'hFFFF_FFFF) begin
        s.last_sample = 1;
        finished = 1;
      end else begin
        now_t = nxt[31:0];
      end
    end
    s.position = held[0];
    s.velocity = held[1];
    s.acceleration = held[2];
    s.sample_time = held[3];
    sample_q = {sample_q, s};
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    sample_t e;
    if (!rst_n) begin
      for (int i = 0; i < qtg_pkg::NUM_CFG; i++) regs[i] = 0;
      regs[qtg_pkg::CFG_DURATION] = qtg_pkg::DURATION_RESET;
      regs[qtg_pkg::CFG_STEP] = qtg_pkg::STEP_RESET;
      for (int i = 0; i < 6; i++) coef[i] = 0;
      for (int i = 0; i < 4; i++) held[i] = 0;
      now_t = 0; run_d = 0; run_s = 0;
      finished = 1; err_flag = 0;
      sample_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sample_q.size() == 0) begin
          report("unexpected word", 32'd0, 32'd0);
        end else begin
          e = sample_q.pop_front();
          if (out_ch.position !== e.position) report("position", out_ch.position, e.position);
          if (out_ch.velocity !== e.velocity) report("velocity", out_ch.velocity, e.velocity);
          if (out_ch.acceleration !== e.acceleration)
            report("acceleration", out_ch.acceleration, e.acceleration);
          if (out_ch.sample_time !== e.sample_time)
            report("sample_time", out_ch.sample_time, e.sample_time);
          if (out_ch.last_sample !== e.last_sample)
            report("last_sample", {31'd0, out_ch.last_sample}, {31'd0, e.last_sample});
          if (out_ch.past_end !== e.past_end)
            report("past_end", {31'd0, out_ch.past_end}, {31'd0, e.past_end});
          if (out_ch.setup_error !== e.setup_error)
            report("setup_error", {31'd0, out_ch.setup_error}, {31'd0, e.setup_error});
        end
      end
      if (in_ch.valid && in_ch.ready) predict_sample(in_ch.restart);
      if (cfg_we) regs[cfg_index] = cfg_data;
    end
    pending = sample_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

>>> test/testbench.sv
// Top of the quintic trajectory generator test: clock, reset, tick and register
// stimulus, sample-side back-pressure and the verdict. Depends on qtg_pkg, the two
// channel interfaces, quintic_trajectory_generator and qtg_sample_checker.
`timescale 1ns / 1ps
module testbench;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int          errors, pending;
  int          ticks_sent = 0;
  int          send_idle = 0, recv_idle = 0, hold_cycles = 0;
  logic [31:0] setup [qtg_pkg::NUM_CFG];

  qtg_in_if  in_ch ();
  qtg_out_if out_ch ();

  quintic_trajectory_generator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  qtg_sample_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // sample side: random stalls plus an optional long hold-off
  initial out_ch.ready = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_tick(logic restart);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_setup();
    for (int i = 0; i < qtg_pkg::NUM_CFG; i++) begin
      cfg_we <= 1;
      cfg_index <= 3'(i);
      cfg_data <= setup[i];
      @(negedge clk);
    end
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic run_ticks(int n);
    for (int i = 0; i < n; i++) send_tick(0);
  endtask

  initial begin
    int k, n;
    in_ch.valid = 0;
    in_ch.restart = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // no run yet, then a run on reset registers with a long sample-side hold
    hold_cycles <= 3000;
    send_tick(0);
    send_tick(1);
    run_ticks(13);
    drain();

    // full-scale endpoints
    setup = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0000_8000};
    load_setup();
    send_tick(1);
    run_ticks(3);
    drain();
    setup = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001};
    load_setup();
    send_tick(1);
    run_ticks(2);
    drain();
    // zero duration, then zero step
    setup[qtg_pkg::CFG_DURATION] = 0;
    setup[qtg_pkg::CFG_STEP] = 32'h1000;
    load_setup();
    send_tick(1);
    send_tick(0);
    drain();
    setup[qtg_pkg::CFG_DURATION] = 32'h1_0000;
    setup[qtg_pkg::CFG_STEP] = 0;
    load_setup();
    send_tick(1);
    drain();
    // time overflow at the widest duration
    setup[qtg_pkg::CFG_DURATION] = 32'hFFFF_FFFF;
    setup[qtg_pkg::CFG_STEP] = 32'hFFFF_FFFF;
    load_setup();
    send_tick(1);
    send_tick(0);
    drain();

    while (ticks_sent < 1800) begin
      if (ticks_sent < 600) begin
        send_idle = 21; recv_idle = 47;
      end else if (ticks_sent < 1200) begin
        send_idle = 47; recv_idle = 21;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      drain();
      for (int i = 0; i < 6; i++) setup[i] = rand_value();
      case ($urandom_range(19))
        0: setup[qtg_pkg::CFG_DURATION] = 0;
        1: setup[qtg_pkg::CFG_DURATION] = $urandom;
        default: setup[qtg_pkg::CFG_DURATION] = $urandom_range(32'h4_0000, 1);
      endcase
      k = $urandom_range(12, 1);
      setup[qtg_pkg::CFG_STEP] = setup[qtg_pkg::CFG_DURATION] / k;
      if (setup[qtg_pkg::CFG_STEP] == 0 || $urandom_range(29) == 0)
        setup[qtg_pkg::CFG_STEP] = $urandom_range(1) ? 32'd0 : $urandom;
      if (setup[qtg_pkg::CFG_STEP] == 0 && setup[qtg_pkg::CFG_DURATION] != 0 &&
          $urandom_range(1))
        setup[qtg_pkg::CFG_STEP] = 1 + setup[qtg_pkg::CFG_DURATION] / 4;
      load_setup();
      // mostly a whole run from restart, sometimes bare ticks or a restart mid-run
      if ($urandom_range(9) != 0) send_tick(1);
      n = k + 1 + $urandom_range(2);
      for (int i = 0; i < n; i++) send_tick($urandom_range(24) == 0);
    end

    drain();
    repeat (1000) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
